FILE: rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and codes for the LIFO free-page list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

  // Request codes carried by the action field
  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_EMPTY      = 3'd1,
    STATUS_BAD_PAGE   = 3'd2,
    STATUS_BAD_BOUNDS = 3'd3,
    STATUS_OVERFLOW   = 3'd4
  } status_e;

  // Classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_NOP        = 3'd0,
    CMD_INIT       = 3'd1,
    CMD_INIT_BAD   = 3'd2,
    CMD_ALLOC      = 3'd3,
    CMD_FREE       = 3'd4,
    CMD_FREE_BAD   = 3'd5
  } cmd_e;

  localparam int unsigned CmdW = $bits(cmd_e);

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_RD_WAIT
  } bk_state_e;

  // Configuration register indexes
  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_END   = 1'b1;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned FieldW  = 32;

  typedef struct packed {
    logic [1:0]        action;
    logic [FieldW-1:0] page_address;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] granted_address;
    status_e           status;
  } out_item_t;

endpackage

FILE: rtl/pfla_fifo.sv
// ----------------------------------------------------------------------------
// pfla_fifo
// Two-entry command queue decoupling the classify front from the back end.
// ----------------------------------------------------------------------------
module pfla_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/pfla_front.sv
// ----------------------------------------------------------------------------
// pfla_front
// Accepts requests and classifies them against the pool bounds.
// ----------------------------------------------------------------------------
module pfla_front #(
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  pfla_pkg::in_item_t                   in_item_i,
  input  logic [ADDR_BITS-1:0]                 pool_start_i,
  input  logic [ADDR_BITS-1:0]                 pool_end_i,
  output pfla_pkg::cmd_e                       cmd_o,
  output logic [ADDR_BITS-PAGE_SHIFT:0]        arg_o
);

  import pfla_pkg::*;

  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned ArgW = ADDR_BITS - PAGE_SHIFT + 1;

  logic [AW-1:0] addr;
  logic [AW-1:0] span;
  logic          bounds_bad;
  logic          page_bad;

  assign addr = AW'(in_item_i.page_address);
  assign span = pool_end_i - pool_start_i;

  // Check alignment and range
  assign bounds_bad = (pool_start_i[PAGE_SHIFT-1:0] != '0) ||
                      (pool_end_i[PAGE_SHIFT-1:0] != '0);
  assign page_bad   = (addr[PAGE_SHIFT-1:0] != '0) || (addr < pool_start_i) ||
                      (addr >= pool_end_i);

  // Classify the request
  always_comb begin
    cmd_o = CMD_NOP;
    arg_o = '0;
    case (action_e'(in_item_i.action))
      ACT_INIT: begin
        if (bounds_bad) begin
          cmd_o = CMD_INIT_BAD;
        end else begin
          cmd_o = CMD_INIT;
          if (pool_end_i > pool_start_i) begin
            arg_o = ArgW'(span >> PAGE_SHIFT);
          end
        end
      end
      ACT_ALLOC: cmd_o = CMD_ALLOC;
      ACT_FREE: begin
        if (page_bad) begin
          cmd_o = CMD_FREE_BAD;
        end else begin
          cmd_o = CMD_FREE;
          arg_o = ArgW'(addr[AW-1:PAGE_SHIFT]);
        end
      end
      default: cmd_o = CMD_NOP;
    endcase
  end

endmodule

FILE: rtl/pfla_back.sv
// ----------------------------------------------------------------------------
// pfla_back
// Executes classified commands on the freed-page stack and fresh pointer.
// ----------------------------------------------------------------------------
module pfla_back #(
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned PAGE_SHIFT  = 12,
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  pfla_pkg::cmd_e                cmd_i,
  input  logic [ADDR_BITS-PAGE_SHIFT:0] arg_i,
  output logic                          cmd_pop_o,
  input  logic [ADDR_BITS-1:0]          pool_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pfla_pkg::out_item_t           out_item_o
);

  import pfla_pkg::*;

  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned PNW = ADDR_BITS - PAGE_SHIFT;
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW  = $clog2(STACK_DEPTH);

  // Freed-page stack memory
  logic [PNW-1:0] stack_mem [STACK_DEPTH];
  logic [PNW-1:0] rd_data_q;
  logic           mem_we;
  logic           rd_en;

  bk_state_e      state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [PNW:0]   fresh_q, fresh_d;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_item_q, out_item_d;

  logic           slot_free;
  logic [CW-1:0]  count_dec;
  logic [PNW:0]   fresh_dec;
  logic [PNW-1:0] fresh_page;
  logic [AW-1:0]  fresh_addr;
  logic [AW-1:0]  popped_addr;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign count_dec   = count_q - CW'(1);
  assign fresh_dec   = fresh_q - (PNW + 1)'(1);
  assign fresh_page  = fresh_dec[PNW-1:0];
  assign fresh_addr  = pool_start_i + {fresh_page, {PAGE_SHIFT{1'b0}}};
  assign popped_addr = {rd_data_q, {PAGE_SHIFT{1'b0}}};

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Next state, stack update and result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o                  = 1'b1;
          out_valid_d                = 1'b1;
          out_item_d.granted_address = '0;
          out_item_d.status          = STATUS_OK;
          case (cmd_i)
            CMD_INIT: begin
              count_d = '0;
              fresh_d = arg_i;
            end
            CMD_INIT_BAD: out_item_d.status = STATUS_BAD_BOUNDS;
            CMD_FREE_BAD: out_item_d.status = STATUS_BAD_PAGE;
            CMD_FREE: begin
              if (count_q == CW'(STACK_DEPTH)) begin
                out_item_d.status = STATUS_OVERFLOW;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_ALLOC: begin
              if (count_q != '0) begin
                // Pop the stack: result waits for the registered read
                rd_en       = 1'b1;
                count_d     = count_dec;
                out_valid_d = 1'b0;
                state_d     = BK_RD_WAIT;
              end else if (fresh_q != '0) begin
                fresh_d                    = fresh_dec;
                out_item_d.granted_address = FieldW'(fresh_addr);
              end else begin
                out_item_d.status = STATUS_EMPTY;
              end
            end
            default: out_item_d.status = STATUS_OK;
          endcase
        end
      end
      BK_RD_WAIT: begin
        if (slot_free) begin
          out_valid_d                = 1'b1;
          out_item_d.granted_address = FieldW'(popped_addr);
          out_item_d.status          = STATUS_OK;
          state_d                    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  // Push on write, registered read on pop
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[count_q[IW-1:0]] <= arg_i[PNW-1:0];
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[count_dec[IW-1:0]];
    end
  end

endmodule

FILE: rtl/page_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator_core
// LIFO free-page allocator: classify front, command queue, stack back end.
// ----------------------------------------------------------------------------
//
//  channel | signals                             | dir | moves per transfer
//  --------+-------------------------------------+-----+---------------------------
//  in      | in_valid_i / in_ready_o / in_item_i | in  | action, page_address
//  out     | out_valid_o / out_ready_i / out_item_o | out | granted_address, status
//  cfg     | cfg_valid_i / cfg_ready_o / cfg_index_i, cfg_data_i | in | pool bound
//
// A request is classified in the cycle it is taken and queued (two entries).
// The back end retires one command per cycle while the output slot is free; an
// allocate served from the freed-page stack also waits in BK_RD_WAIT for the
// registered stack read and takes no new command meanwhile. Results are registered.
// Reset empties the queue and pool; the stack memory needs no clearing.
// A stalled output holds the back end; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module page_free_list_allocator_core #(
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned PAGE_SHIFT  = 12,
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pfla_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pfla_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pfla_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pfla_pkg::FieldW-1:0]     cfg_data_i
);

  import pfla_pkg::*;

  localparam int unsigned AW   = ADDR_BITS;
  localparam int unsigned ArgW = ADDR_BITS - PAGE_SHIFT + 1;
  localparam int unsigned QW   = CmdW + ArgW;

  logic [FieldW-1:0] pool_start_q;
  logic [FieldW-1:0] pool_end_q;
  logic [AW-1:0]     pool_start;
  logic [AW-1:0]     pool_end;

  cmd_e              front_cmd;
  logic [ArgW-1:0]   front_arg;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic [QW-1:0]     q_data;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= '0;
      pool_end_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POOL_START: pool_start_q <= cfg_data_i;
        CFG_POOL_END:   pool_end_q   <= cfg_data_i;
        default:        pool_start_q <= pool_start_q;
      endcase
    end
  end

  assign pool_start = AW'(pool_start_q);
  assign pool_end   = AW'(pool_end_q);

  // Accept requests while the queue has room
  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  pfla_front #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .in_item_i    (in_item_i),
    .pool_start_i (pool_start),
    .pool_end_i   (pool_end),
    .cmd_o        (front_cmd),
    .arg_o        (front_arg)
  );

  pfla_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({front_cmd, front_arg}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  pfla_back #(
    .ADDR_BITS   (ADDR_BITS),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (cmd_e'(q_data[QW-1:ArgW])),
    .arg_i        (q_data[ArgW-1:0]),
    .cmd_pop_o    (q_pop),
    .pool_start_i (pool_start),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
